// ===== rtl/core/ifs_pkg.sv =====
// Shared types, codes and character helpers for the integer field scanner.
`timescale 1ns / 1ps

package ifs_pkg;

    // Default sizes of the accumulator and of the unlimited field width.
    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_MAX_FIELD  = 255;

    // Conversion kinds held in the conv_mode register.
    localparam logic [2:0] MODE_D = 3'd0;
    localparam logic [2:0] MODE_I = 3'd1;
    localparam logic [2:0] MODE_O = 3'd2;
    localparam logic [2:0] MODE_U = 3'd3;
    localparam logic [2:0] MODE_X = 3'd4;

    // Result sizes held in the size_mode register.
    localparam logic [1:0] SIZE_32 = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_64 = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CONV  = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_SIZE  = 2'd2;

    // Character codes the scanner looks for.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Marks a character that is no digit in any radix.
    localparam logic [4:0] DIGIT_NONE = 5'd31;

    // Scan phase, one-hot.
    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_START  = 5'b00010,
        PH_BODY   = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    // Flags of a finished field, passed from the scanner to the formatter.
    typedef struct packed {
        logic neg;
        logic seen;
        logic consumed;
    } t_ev_ctl;

    // Undefined conversion kinds behave as decimal.
    function automatic logic [2:0] eff_mode(input logic [2:0] mode);
        return (mode > MODE_X) ? MODE_D : mode;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Digit value of a character, or DIGIT_NONE.
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            d = 5'(c - CH_ZERO);
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            d = 5'(c - CH_LA) + 5'd10;
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            d = 5'(c - CH_UA) + 5'd10;
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/integer_field_scanner.sv =====
// Top level of the integer field scanner: config port, field register and formatter.
//
// Usage: characters arrive one per transfer on i_char_code (i_valid / o_ready).
// Leading white space is skipped, then a d, i, o, u or x field is scanned.
// When the field ends (end of string, a character that does not fit, or the
// width limit) one result transfer leaves on o_valid / i_ready carrying the
// value, the matched and consumed_last flags and the field length.
// Throughput is one character per cycle while o_ready is high; the scan
// step is a shift-add multiply by 8, 10 or 16 plus the digit. The scan logic
// loads the field register with the transfer of the character that ended the
// field, and the formatter that negates and truncates the value loads the
// output register from the field register, which raises o_valid.
// When the receiver stalls, the finished field waits in the field register
// and the output register; o_ready drops only when both are occupied.
// Reset clears the scan state and the registers conv_mode, max_width and
// size_mode; the APB-style port has pready tied high, registers at 0, 4, 8.
// Registers are to be written only while no field is in progress.
`timescale 1ns / 1ps

module integer_field_scanner import ifs_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_FIELD  = DEF_MAX_FIELD,
    localparam int CNT_MAX   = (MAX_FIELD > 255) ? MAX_FIELD : 255,
    localparam int CNT_W     = $clog2(CNT_MAX + 1),
    localparam int B32       = (VALUE_BITS < 32) ? VALUE_BITS : 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Character channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char_code,
    // Result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_value,
    output logic               o_matched,
    output logic               o_consumed_last,
    output logic [7:0]         o_field_length,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [2:0] r_conv;
    logic [7:0] r_width;
    logic [1:0] r_size;

    logic                  take;
    logic                  ev_free;
    logic                  out_free;
    logic                  scan_fire;
    t_ev_ctl               scan_ctl;
    logic [VALUE_BITS-1:0] scan_acc;
    logic [CNT_W-1:0]      scan_count;

    logic                  r_ev_valid;
    t_ev_ctl               r_ev_ctl;
    logic [VALUE_BITS-1:0] r_ev_acc;
    logic [CNT_W-1:0]      r_ev_count;

    logic                  r_o_valid;
    logic [63:0]           r_value;
    logic                  r_matched;
    logic                  r_consumed;
    logic [7:0]            r_len;

    logic [2:0]            fmt_mode;
    logic [VALUE_BITS-1:0] fmt_signed;
    logic [63:0]           fmt_ext;
    logic [6:0]            fmt_bits;
    logic                  fmt_sign;
    logic                  fmt_sx;
    logic [63:0]           fmt_value;
    logic [7:0]            fmt_len;

    // Configuration writes and reads.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv  <= MODE_D;
            r_width <= 8'd0;
            r_size  <= SIZE_32;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_CONV:  r_conv  <= pwdata[2:0];
                REG_WIDTH: r_width <= pwdata[7:0];
                REG_SIZE:  r_size  <= pwdata[1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CONV:  prdata = {29'd0, r_conv};
            REG_WIDTH: prdata = {24'd0, r_width};
            REG_SIZE:  prdata = {30'd0, r_size};
            default:   prdata = 32'd0;
        endcase
    end

    // Handshake: each stage moves on when the stage after it is free.
    assign out_free = !r_o_valid || i_ready;
    assign ev_free  = !r_ev_valid || out_free;
    assign o_ready  = ev_free;
    assign take     = i_valid && ev_free;

    ifs_scan #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_code (i_char_code),
        .i_conv_mode (r_conv),
        .i_max_width (r_width),
        .o_fire      (scan_fire),
        .o_ctl       (scan_ctl),
        .o_acc       (scan_acc),
        .o_count     (scan_count)
    );

    // Finished field register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (take && scan_fire) begin
            r_ev_valid <= 1'b1;
        end else if (out_free) begin
            r_ev_valid <= 1'b0;
        end
        if (take && scan_fire) begin
            r_ev_ctl   <= scan_ctl;
            r_ev_acc   <= scan_acc;
            r_ev_count <= scan_count;
        end
    end

    // Formatter: negate, truncate to the result size, then extend.
    always_comb begin
        fmt_mode   = eff_mode(r_conv);
        fmt_sx     = (fmt_mode == MODE_D) || (fmt_mode == MODE_I);
        fmt_signed = r_ev_ctl.neg ? (VALUE_BITS'(0) - r_ev_acc) : r_ev_acc;
        fmt_ext    = 64'(fmt_signed);
        unique case (r_size)
            SIZE_16: fmt_bits = 7'd16;
            SIZE_64: fmt_bits = 7'(VALUE_BITS);
            default: fmt_bits = 7'(B32);
        endcase
        fmt_sign = fmt_ext[6'(fmt_bits - 7'd1)];
        for (int i = 0; i < 64; i++) begin
            fmt_value[i] = (7'(i) < fmt_bits) ? fmt_ext[i] : (fmt_sx && fmt_sign);
        end
        if (!r_ev_ctl.seen) begin
            fmt_value = 64'd0;
        end
        fmt_len = (r_ev_count >= CNT_W'(255)) ? 8'd255 : r_ev_count[7:0];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_ev_valid;
        end
        if (out_free && r_ev_valid) begin
            r_value    <= fmt_value;
            r_matched  <= r_ev_ctl.seen;
            r_consumed <= r_ev_ctl.consumed;
            r_len      <= fmt_len;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_value         = r_value;
    assign o_matched       = r_matched;
    assign o_consumed_last = r_consumed;
    assign o_field_length  = r_len;

    // A full pipeline with a stalled receiver takes no new character.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ev_valid && r_o_valid && !i_ready) |-> !o_ready)
        else $error("character taken while both result stages are full");

    // A pending field moves into a free result register.
    a_field_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ev_valid && out_free) |=> o_valid)
        else $error("finished field lost on the way to the output");

    // Without a digit the value is zero.
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_matched) |-> (o_value == 64'sd0))
        else $error("unmatched field carries a nonzero value");

    // A field closed by the width limit took at least one character.
    a_consumed_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_consumed_last) |-> (o_field_length != 8'd0))
        else $error("width limit reached with an empty field");

endmodule

// ===== rtl/core/ifs_scan.sv =====
// Character scanner: white space, sign, radix prefix and digit accumulation.
`timescale 1ns / 1ps

module ifs_scan import ifs_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_FIELD  = DEF_MAX_FIELD,
    localparam int CNT_MAX   = (MAX_FIELD > 255) ? MAX_FIELD : 255,
    localparam int CNT_W     = $clog2(CNT_MAX + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_char_code,
    input  logic [2:0]            i_conv_mode,
    input  logic [7:0]            i_max_width,
    output logic                  o_fire,
    output t_ev_ctl               o_ctl,
    output logic [VALUE_BITS-1:0] o_acc,
    output logic [CNT_W-1:0]      o_count
);

    t_phase                r_phase, n_phase;
    t_radix                r_radix, n_radix;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_seen, n_seen;
    logic [CNT_W-1:0]      r_count, n_count;

    logic [2:0]            mode;
    logic [4:0]            dig;
    logic [4:0]            radv;
    t_phase                eph;
    t_radix                drad;
    logic [VALUE_BITS-1:0] prod;
    logic [CNT_W-1:0]      limit;
    logic                  idle_char;
    logic                  try_d;
    logic                  fail;
    logic                  fire;
    logic                  consumed;

    // Next state for one character, following the phases of the field.
    always_comb begin
        mode  = eff_mode(i_conv_mode);
        dig   = digit_of(i_char_code);
        limit = (i_max_width != 8'd0) ? CNT_W'(i_max_width) : CNT_W'(MAX_FIELD);

        n_phase  = r_phase;
        n_radix  = r_radix;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_seen   = r_seen;
        n_count  = r_count;
        try_d    = 1'b0;
        fail     = 1'b0;
        fire     = 1'b0;
        consumed = 1'b0;

        // The first character after white space opens the field.
        eph  = r_phase;
        drad = r_radix;
        if (r_phase == PH_SKIP) begin
            eph = PH_START;
            if (mode == MODE_O) begin
                drad = RX_OCT;
            end else if (mode == MODE_X) begin
                drad = RX_HEX;
            end else begin
                drad = RX_DEC;
            end
        end
        idle_char = (r_phase == PH_SKIP) &&
                    (is_space(i_char_code) || (i_char_code == CH_NUL));

        if (!idle_char) begin
            priority if ((eph == PH_START) &&
                         ((i_char_code == CH_PLUS) || (i_char_code == CH_MINUS))) begin
                n_neg   = (i_char_code == CH_MINUS);
                n_count = r_count + CNT_W'(1);
                n_phase = PH_BODY;
                n_radix = drad;
            end else if (((eph == PH_START) || (eph == PH_BODY)) &&
                         ((mode == MODE_I) || (mode == MODE_X)) &&
                         (i_char_code == CH_ZERO)) begin
                n_seen  = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_phase = PH_ZERO;
                n_radix = drad;
            end else if ((eph == PH_ZERO) &&
                         ((i_char_code == CH_LX) || (i_char_code == CH_UX))) begin
                n_radix = RX_HEX;
                n_count = r_count + CNT_W'(1);
                n_phase = PH_DIGITS;
            end else begin
                // A leading zero in mode i switches to octal.
                if ((eph == PH_ZERO) && (mode == MODE_I)) begin
                    drad = RX_OCT;
                end
                n_radix = drad;
                n_phase = PH_DIGITS;
                try_d   = 1'b1;
            end
        end

        // Multiply by the radix with shifts, then add the digit.
        unique case (drad)
            RX_OCT:  prod = r_acc << 3;
            RX_HEX:  prod = r_acc << 4;
            default: prod = (r_acc << 3) + (r_acc << 1);
        endcase
        unique case (drad)
            RX_OCT:  radv = 5'd8;
            RX_HEX:  radv = 5'd16;
            default: radv = 5'd10;
        endcase

        if (try_d) begin
            if (dig < radv) begin
                n_acc   = prod + VALUE_BITS'(dig[3:0]);
                n_seen  = 1'b1;
                n_count = r_count + CNT_W'(1);
            end else begin
                fail = 1'b1;
            end
        end

        // A field ends on end of string, a rejected character or the width limit.
        if (idle_char) begin
            fire = (i_char_code == CH_NUL);
        end else begin
            fire     = fail || (n_count >= limit);
            consumed = !fail;
        end
    end

    // Scan state; everything returns to its reset value after a field ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_radix <= RX_DEC;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
            r_count <= '0;
        end else if (i_take) begin
            if (fire) begin
                r_phase <= PH_SKIP;
                r_radix <= RX_DEC;
                r_acc   <= '0;
                r_neg   <= 1'b0;
                r_seen  <= 1'b0;
                r_count <= '0;
            end else begin
                r_phase <= n_phase;
                r_radix <= n_radix;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_seen  <= n_seen;
                r_count <= n_count;
            end
        end
    end

    assign o_fire         = fire;
    assign o_ctl.neg      = n_neg;
    assign o_ctl.seen     = n_seen;
    assign o_ctl.consumed = consumed;
    assign o_acc          = n_acc;
    assign o_count        = n_count;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the integer field scanner: directed and random text streams.
`timescale 1ns / 1ps

module testbench;
    import ifs_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 70;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_FIELD     = 260;

    // Codes outside the defined ranges, which the block maps to defaults.
    localparam logic [2:0] MODE_UNDEF = 3'd7;
    localparam logic [1:0] SIZE_UNDEF = 2'd3;

    // Expected content of one result transfer.
    typedef struct {
        logic [63:0] value;
        logic        matched;
        logic        consumed;
        logic [7:0]  length;
    } field_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_char_code = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [63:0] o_value;
    logic               o_matched;
    logic               o_consumed_last;
    logic [7:0]         o_field_length;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Pending characters and the results they are expected to produce.
    logic [7:0]    char_q[$];
    field_result_t field_q[$];

    // Scanner shadow: register copies and field state.
    logic [2:0]  cfg_conv = MODE_D;
    logic [7:0]  cfg_width = '0;
    logic [1:0]  cfg_size = SIZE_32;
    t_phase      scan_ph = PH_SKIP;
    t_radix      scan_rdx = RX_DEC;
    logic [63:0] scan_acc = '0;
    logic        scan_neg = 1'b0;
    logic        scan_seen = 1'b0;
    int          scan_taken = 0;

    // Traffic shaping and bookkeeping.
    int send_gap_max = 0;
    int recv_gap_max = 0;
    bit hold_armed = 1'b0;
    int items_queued = 0;
    int chars_accepted = 0;
    int results_checked = 0;
    int settings_used = 0;
    int fail_count = 0;
    int input_stall_cycles = 0;

    integer_field_scanner u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_code     (i_char_code),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_value         (o_value),
        .o_matched       (o_matched),
        .o_consumed_last (o_consumed_last),
        .o_field_length  (o_field_length),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Conversion kind in effect; unknown codes scan as decimal.
    function automatic logic [2:0] active_kind();
        return (cfg_conv <= MODE_X) ? cfg_conv : MODE_D;
    endfunction

    function automatic int char_digit(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return 99;
    endfunction

    function automatic void clear_field();
        scan_ph    = PH_SKIP;
        scan_rdx   = RX_DEC;
        scan_acc   = '0;
        scan_neg   = 1'b0;
        scan_seen  = 1'b0;
        scan_taken = 0;
    endfunction

    // Folds one digit into the accumulator if it fits the current radix.
    function automatic bit add_digit(logic [7:0] c);
        int d;
        int base;
        d = char_digit(c);
        base = 10;
        if (scan_rdx == RX_OCT) base = 8;
        else if (scan_rdx == RX_HEX) base = 16;
        if (d >= base) return 1'b0;
        scan_acc = scan_acc * 64'(base) + 64'(d);
        scan_seen = 1'b1;
        scan_taken++;
        return 1'b1;
    endfunction

    // Offers one character to a field in progress; returns 1 if it was taken.
    function automatic bit take_char(logic [7:0] c, logic [2:0] kind);
        if (scan_ph == PH_START) begin
            scan_ph = PH_BODY;
            if (c == CH_PLUS || c == CH_MINUS) begin
                scan_neg = (c == CH_MINUS);
                scan_taken++;
                return 1'b1;
            end
        end
        if (scan_ph == PH_BODY) begin
            if ((kind == MODE_I || kind == MODE_X) && c == CH_ZERO) begin
                scan_seen = 1'b1;
                scan_taken++;
                scan_ph = PH_ZERO;
                return 1'b1;
            end
            scan_ph = PH_DIGITS;
            return add_digit(c);
        end
        if (scan_ph == PH_ZERO) begin
            scan_ph = PH_DIGITS;
            if (c == CH_LX || c == CH_UX) begin
                scan_rdx = RX_HEX;
                scan_taken++;
                return 1'b1;
            end
            if (kind == MODE_I) scan_rdx = RX_OCT;
        end
        return add_digit(c);
    endfunction

    // Closes the field: sign, truncation to the size and extension.
    function automatic void close_field(bit consumed);
        field_result_t r;
        logic [2:0]    kind;
        int            bits;
        logic [63:0]   mask;
        logic [63:0]   v;
        kind = active_kind();
        bits = 32;
        if (cfg_size == SIZE_16) bits = 16;
        else if (cfg_size == SIZE_64) bits = 64;
        mask = (bits == 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
        v = '0;
        if (scan_seen) begin
            v = scan_neg ? (64'd0 - scan_acc) : scan_acc;
            v &= mask;
            if ((kind == MODE_D || kind == MODE_I) && v[bits-1]) v |= ~mask;
        end
        r.value    = v;
        r.matched  = scan_seen;
        r.consumed = consumed;
        r.length   = (scan_taken > 255) ? 8'd255 : 8'(scan_taken);
        field_q.push_back(r);
        clear_field();
    endfunction

    // Advances the shadow scanner by one accepted character.
    function automatic void scan_char(logic [7:0] c);
        logic [2:0] kind;
        int         limit;
        kind = active_kind();
        limit = (cfg_width != 0) ? int'(cfg_width) : DEF_MAX_FIELD;
        if (scan_ph == PH_SKIP) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
            if (c == CH_NUL) begin
                close_field(1'b0);
                return;
            end
            scan_ph = PH_START;
            if (kind == MODE_O) scan_rdx = RX_OCT;
            else if (kind == MODE_X) scan_rdx = RX_HEX;
            else scan_rdx = RX_DEC;
        end
        if (!take_char(c, kind)) close_field(1'b0);
        else if (scan_taken >= limit) close_field(1'b1);
    endfunction

    // Character driver: one transfer per item, random gap after each item.
    always @(posedge i_clk) begin : char_driver
        logic nxt_valid;
        int   send_gap;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && o_ready) begin
                scan_char(i_char_code);
                chars_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (char_q.size() > 0) begin
                    i_char_code <= char_q.pop_front();
                    nxt_valid = 1'b1;
                    send_gap = $urandom_range(0, send_gap_max);
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // Result monitor: checks every transfer and paces the ready signal.
    always @(posedge i_clk) begin : result_monitor
        logic          nxt_ready;
        int            recv_wait;
        int            hold_left;
        field_result_t exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_wait = 0;
            hold_left = -1;
        end else begin
            nxt_ready = i_ready;
            if (o_valid && i_ready) begin
                results_checked++;
                if (field_q.size() == 0) begin
                    $error("result transfer with no field pending: value %h", o_value);
                    fail_count++;
                end else begin
                    exp_r = field_q.pop_front();
                    if (o_value !== exp_r.value) begin
                        $error("value: expected %h, got %h", exp_r.value, o_value);
                        fail_count++;
                    end
                    if (o_matched !== exp_r.matched) begin
                        $error("matched: expected %b, got %b", exp_r.matched, o_matched);
                        fail_count++;
                    end
                    if (o_consumed_last !== exp_r.consumed) begin
                        $error("consumed_last: expected %b, got %b",
                               exp_r.consumed, o_consumed_last);
                        fail_count++;
                    end
                    if (o_field_length !== exp_r.length) begin
                        $error("field_length: expected %0d, got %0d",
                               exp_r.length, o_field_length);
                        fail_count++;
                    end
                end
                nxt_ready = 1'b0;
                recv_wait = $urandom_range(0, recv_gap_max);
            end
            // A long hold-off fills the block so that it stalls its input.
            if (hold_armed && hold_left < 0) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (!nxt_ready) begin
                if (recv_wait > 0) recv_wait--;
                else nxt_ready = 1'b1;
            end
            i_ready <= nxt_ready;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n) begin
            quiet = 0;
        end else begin
            if (i_valid && !o_ready) input_stall_cycles++;
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d results still pending", field_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic push_char(logic [7:0] c);
        char_q.push_back(c);
        items_queued++;
    endtask

    task automatic push_str(string s);
        for (int k = 0; k < s.len(); k++) push_char(s[k]);
    endtask

    function automatic logic [7:0] space_char();
        int s;
        s = $urandom_range(8, 13);
        return (s == 8) ? CH_SPACE : 8'(s);
    endfunction

    function automatic logic [7:0] digit_char(int base);
        int d;
        d = $urandom_range(0, base - 1);
        if (d < 10) return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
    endfunction

    // Well-formed field with random content and a random terminator.
    task automatic push_field(logic [2:0] kind);
        int base;
        int pick;
        int n;
        repeat ($urandom_range(0, 2)) push_char(space_char());
        pick = $urandom_range(0, 9);
        if (pick < 2) push_char(CH_MINUS);
        else if (pick < 3) push_char(CH_PLUS);
        base = 10;
        if (kind == MODE_O) base = 8;
        else if (kind == MODE_X) base = 16;
        if ((kind == MODE_I || kind == MODE_X) && $urandom_range(0, 2) == 0) begin
            push_char(CH_ZERO);
            pick = $urandom_range(0, 3);
            if (pick < 2) begin
                push_char(pick == 0 ? CH_LX : CH_UX);
                base = 16;
            end else if (kind == MODE_I) begin
                base = 8;
            end
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
        repeat (n) push_char(digit_char(base));
        pick = $urandom_range(0, 5);
        if (pick == 0) push_char(CH_NUL);
        else if (pick < 3) push_char(space_char());
        else if (pick == 3) push_char(CH_MINUS);
        else push_char(8'($urandom_range(0, 255)));
    endtask

    // APB write: setup cycle, then access cycle; shadow copy follows the write.
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CONV:  cfg_conv = data[2:0];
            REG_WIDTH: cfg_width = data[7:0];
            REG_SIZE:  cfg_size = data[1:0];
            default: ;
        endcase
    endtask

    // Waits until every character is sent and every result is checked.
    task automatic wait_drained();
        @(negedge i_clk);
        while (char_q.size() != 0 || i_valid || field_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [2:0] conv;
        logic [7:0] width;
        logic [1:0] size;
        int         target;
        clear_field();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed text under the reset settings: end of string before a
        // field, a negative number, a lone sign, a bad first character and
        // a 32-bit wraparound.
        push_char(CH_NUL);
        push_str("\t -12x");
        push_str("+ ");
        push_str("z");
        push_str("4294967295");
        push_char(CH_NUL);
        wait_drained();
        settings_used++;

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin conv = MODE_I;     width = 8'd0;   size = SIZE_64;    end
                1: begin conv = MODE_X;     width = 8'd255; size = SIZE_16;    end
                2: begin conv = MODE_O;     width = 8'd1;   size = SIZE_32;    end
                3: begin conv = MODE_U;     width = 8'd0;   size = SIZE_64;    end
                4: begin conv = MODE_D;     width = 8'd0;   size = SIZE_UNDEF; end
                5: begin conv = MODE_UNDEF; width = 8'd5;   size = SIZE_16;    end
                6: begin conv = MODE_I;     width = 8'd3;   size = SIZE_64;    end
                7: begin conv = MODE_X;     width = 8'd2;   size = SIZE_32;    end
                default: begin
                    conv = 3'($urandom_range(0, 7));
                    width = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 6));
                    size = 2'($urandom_range(0, 3));
                end
            endcase
            write_reg(REG_CONV, 32'(conv));
            write_reg(REG_WIDTH, 32'(width));
            write_reg(REG_SIZE, 32'(size));
            settings_used++;
            send_gap_max = (p % 4 == 1 || p % 4 == 3) ? 9 : 0;
            recv_gap_max = (p % 4 >= 2) ? 9 : 0;
            if (p == 2) hold_armed = 1'b1;

            // Corner text for the fixed settings.
            case (p)
                0: begin
                    // Zero then 8 ends an octal field; a lone 0x still matches.
                    push_str("08 0x");
                    push_char(CH_NUL);
                    push_str("-9223372036854775808 0x1F,077 ");
                end
                1: push_str("0X -0xffff 7fff 0x");
                3: push_str("18446744073709551615 -1 ");
                4: begin
                    // Unlimited width closes a field after the maximum count.
                    repeat (LONG_FIELD) push_char(CH_ZERO + 8'($urandom_range(1, 9)));
                    push_char(CH_SPACE);
                end
                5: push_str("-32768 ");
                6: push_str("0x7f 09");
                7: push_str("0x1 ");
                default: ;
            endcase

            // Mostly well-formed fields, with raw bytes as noise.
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target) begin
                if ($urandom_range(0, 4) != 0) push_field(active_kind());
                else push_char(8'($urandom_range(0, 255)));
            end
            // End of string guarantees that no field is left open.
            push_char(CH_NUL);
            wait_drained();
        end

        $display("Scanned %0d characters into %0d checked results over %0d settings.",
                 chars_accepted, results_checked, settings_used);
        $display("All conversion kinds, sizes and width extremes; input stalled %0d cycles.",
                 input_stall_cycles);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
